/* src/p2p_pkg.sv */
// types, constants and lookup tables shared by the phonetic-notation parser
`default_nettype none

package p2p_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] STRESS_DEFAULT   = 2'd1;
    localparam logic [1:0] STRESS_PRIMARY   = 2'd2;
    localparam logic [1:0] STRESS_SECONDARY = 2'd3;

    localparam logic [5:0] MAX_PHONES_RESET = 6'd31;

    // bit k set when phoneme k is syllabic
    localparam logic [63:0] SYL_MASK = 64'h0007_1060_3F81_863F;

    typedef enum logic [3:0] {
        ST_START,
        ST_LPAREN,
        ST_LPAREN_AT,
        ST_A_LO,
        ST_AT,
        ST_A_UP,
        ST_O_UP,
        ST_D,
        ST_E,
        ST_H,
        ST_O_LO,
        ST_T,
        ST_W_UP
    } parse_state_t;

    typedef enum logic [2:0] {
        ACT_PHONE,
        ACT_SILENT,
        ACT_PRIMARY,
        ACT_SECONDARY,
        ACT_LOOK,
        ACT_END,
        ACT_UNKNOWN
    } act_t;

    typedef struct packed {
        act_t         kind;
        logic [5:0]   phone;
        parse_state_t next;
    } start_entry_t;

    typedef struct packed {
        logic       to_lparen_at;
        logic       match;
        logic [5:0] match_phone;
        logic       has_dflt;
        logic [5:0] dflt_phone;
    } look_entry_t;

    typedef struct packed {
        parse_state_t parse_state;
        logic [1:0]   pending_stress;
        logic [5:0]   phones;
        logic [5:0]   syllables;
        logic         discarding;
    } word_state_t;

    typedef struct packed {
        logic       is_phone;
        logic [5:0] phone_id;
        logic [1:0] stress;
        logic       word_done;
        logic       parse_error;
        logic [5:0] phone_count;
        logic [5:0] syllable_count;
        logic       last_of_run;
    } result_t;

    function automatic start_entry_t start_lookup(input logic [7:0] c);
        start_entry_t e;
        e.kind  = ACT_PHONE;
        e.phone = 6'd0;
        e.next  = ST_START;
        case (c)
            "&":  e.phone = 6'd0;
            "-":  e.phone = 6'd5;
            "D":  e.phone = 6'd35;
            "E":  e.phone = 6'd9;
            "I":  e.phone = 6'd15;
            "N":  e.phone = 6'd21;
            "R":  e.phone = 6'd46;
            "S":  e.phone = 6'd32;
            "T":  e.phone = 6'd34;
            "U":  e.phone = 6'd29;
            "Y":  e.phone = 6'd49;
            "V":  e.phone = 6'd39;
            "Z":  e.phone = 6'd42;
            "b":  e.phone = 6'd6;
            "f":  e.phone = 6'd11;
            "g":  e.phone = 6'd12;
            "i":  e.phone = 6'd10;
            "j":  e.phone = 6'd41;
            "k":  e.phone = 6'd18;
            "l":  e.phone = 6'd19;
            "m":  e.phone = 6'd20;
            "n":  e.phone = 6'd22;
            "p":  e.phone = 6'd30;
            "r":  e.phone = 6'd31;
            "s":  e.phone = 6'd33;
            "u":  e.phone = 6'd28;
            "v":  e.phone = 6'd39;
            "w":  e.phone = 6'd40;
            "x":  e.phone = 6'd47;
            "y":  e.phone = 6'd48;
            "z":  e.phone = 6'd43;
            "/", "_": e.kind = ACT_SILENT;
            "'":  e.kind = ACT_PRIMARY;
            ",":  e.kind = ACT_SECONDARY;
            "(", "[":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_LPAREN;
            end
            "@":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_AT;
            end
            "A":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_A_UP;
            end
            "O":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_O_UP;
            end
            "W":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_W_UP;
            end
            "d":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_D;
            end
            "a":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_A_LO;
            end
            "e":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_E;
            end
            "h":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_H;
            end
            "o":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_O_LO;
            end
            "t":
            begin
                e.kind = ACT_LOOK;
                e.next = ST_T;
            end
            8'h00:   e.kind = ACT_END;
            default: e.kind = ACT_UNKNOWN;
        endcase
        return e;
    endfunction

    function automatic look_entry_t look_lookup(input parse_state_t s, input logic [7:0] c);
        look_entry_t e;
        e = '0;
        case (s)
            ST_LPAREN:    e.to_lparen_at = (c == "@");
            ST_LPAREN_AT:
            begin
                e.match       = (c == ")") || (c == "]");
                e.match_phone = 6'd1;
            end
            ST_AT:
            begin
                e.match       = (c == "r");
                e.match_phone = 6'd38;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd4;
            end
            ST_A_UP:
            begin
                e.match       = (c == "U");
                e.match_phone = 6'd25;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd2;
            end
            ST_O_UP:
            begin
                e.match       = (c == "i");
                e.match_phone = 6'd23;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd26;
            end
            ST_W_UP:
            begin
                e.match       = (c == "A");
                e.match_phone = 6'd50;
            end
            ST_D:
            begin
                e.match       = (c == "Z");
                e.match_phone = 6'd17;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd8;
            end
            ST_A_LO:
            begin
                e.match       = (c == "I");
                e.match_phone = 6'd16;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd0;
            end
            ST_E:
            begin
                e.match       = (c == "I");
                e.match_phone = 6'd3;
            end
            ST_H:
            begin
                e.match       = (c == "w");
                e.match_phone = 6'd14;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd13;
            end
            ST_O_LO:
            begin
                e.match       = (c == "U");
                e.match_phone = 6'd27;
            end
            ST_T:
            begin
                e.match       = (c == "S");
                e.match_phone = 6'd7;
                e.has_dflt    = 1'b1;
                e.dflt_phone  = 6'd36;
            end
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

/* src/p2p_core.sv */
// next-state and result logic for one character, up to two results
`default_nettype none

module p2p_core
    import p2p_pkg::*;
(
    input  wire word_state_t ws,
    input  wire logic [7:0]  char_code,
    input  wire logic [5:0]  max_phones,
    output word_state_t      ws_next,
    output logic [1:0]       res_count,
    output result_t          res0,
    output result_t          res1
);

    typedef struct packed {
        word_state_t st;
        logic        emit;
        result_t     res;
        logic        again;
        logic        err;
    } pass_t;

    typedef struct packed {
        word_state_t st;
        result_t     res;
    } phone_t;

    function automatic word_state_t clear_word(input word_state_t s);
        word_state_t r;
        r                = s;
        r.parse_state    = ST_START;
        r.pending_stress = STRESS_DEFAULT;
        r.phones         = 6'd0;
        r.syllables      = 6'd0;
        return r;
    endfunction

    function automatic result_t err_result();
        result_t r;
        r             = '0;
        r.parse_error = 1'b1;
        return r;
    endfunction

    function automatic phone_t emit_phone(input word_state_t s, input logic [5:0] id);
        phone_t p;
        p.st         = s;
        p.res        = '0;
        p.res.is_phone = 1'b1;
        p.res.phone_id = id;
        if (SYL_MASK[id])
        begin
            p.res.stress        = s.pending_stress;
            p.st.pending_stress = STRESS_DEFAULT;
            p.st.syllables      = 6'(s.syllables + 6'd1);
        end
        p.st.phones = 6'(s.phones + 6'd1);
        return p;
    endfunction

    function automatic pass_t one_pass(input word_state_t s, input logic [7:0] c,
                                       input logic [5:0] lim);
        pass_t        o;
        look_entry_t  le;
        start_entry_t se;
        phone_t       ph;
        o       = '0;
        o.st    = s;
        le      = look_lookup(s.parse_state, c);
        se      = start_lookup(c);
        if (s.phones >= lim)
        begin
            o.err = 1'b1;
        end
        else if (s.parse_state != ST_START)
        begin
            if (le.to_lparen_at)
            begin
                o.st.parse_state = ST_LPAREN_AT;
            end
            else if (le.match)
            begin
                o.st.parse_state = ST_START;
                ph     = emit_phone(o.st, le.match_phone);
                o.st   = ph.st;
                o.res  = ph.res;
                o.emit = 1'b1;
            end
            else if (le.has_dflt)
            begin
                o.st.parse_state = ST_START;
                ph      = emit_phone(o.st, le.dflt_phone);
                o.st    = ph.st;
                o.res   = ph.res;
                o.emit  = 1'b1;
                o.again = 1'b1;
            end
            else
            begin
                o.err = 1'b1;
            end
        end
        else
        begin
            case (se.kind)
                ACT_PHONE:
                begin
                    ph     = emit_phone(s, se.phone);
                    o.st   = ph.st;
                    o.res  = ph.res;
                    o.emit = 1'b1;
                end
                ACT_SILENT:    o.st = s;
                ACT_PRIMARY:   o.st.pending_stress = STRESS_PRIMARY;
                ACT_SECONDARY: o.st.pending_stress = STRESS_SECONDARY;
                ACT_LOOK:      o.st.parse_state = se.next;
                ACT_END:
                begin
                    o.res.word_done      = 1'b1;
                    o.res.phone_count    = s.phones;
                    o.res.syllable_count = s.syllables;
                    o.emit               = 1'b1;
                    o.st                 = clear_word(s);
                end
                default: o.err = 1'b1;
            endcase
        end
        return o;
    endfunction

    pass_t p1;
    pass_t p2;

    assign p1 = one_pass(ws, char_code, max_phones);
    assign p2 = one_pass(p1.st, char_code, max_phones);

    always_comb
    begin
        ws_next   = ws;
        res_count = 2'd0;
        res0      = '0;
        res1      = '0;
        if (ws.discarding)
        begin
            if (char_code == 8'h00)
            begin
                ws_next            = clear_word(ws);
                ws_next.discarding = 1'b0;
            end
        end
        else if (p1.err)
        begin
            res0               = err_result();
            res0.last_of_run   = 1'b1;
            res_count          = 2'd1;
            ws_next            = clear_word(ws);
            ws_next.discarding = (char_code != 8'h00);
        end
        else if (p1.again)
        begin
            res0 = p1.res;
            if (p2.err)
            begin
                res1               = err_result();
                res1.last_of_run   = 1'b1;
                res_count          = 2'd2;
                ws_next            = clear_word(p1.st);
                ws_next.discarding = (char_code != 8'h00);
            end
            else if (p2.emit)
            begin
                res1             = p2.res;
                res1.last_of_run = 1'b1;
                res_count        = 2'd2;
                ws_next          = p2.st;
            end
            else
            begin
                res0.last_of_run = 1'b1;
                res_count        = 2'd1;
                ws_next          = p2.st;
            end
        end
        else
        begin
            res0             = p1.res;
            res0.last_of_run = p1.emit;
            res_count        = {1'b0, p1.emit};
            ws_next          = p1.st;
        end
    end

endmodule

`default_nettype wire

/* src/p2p_res_queue.sv */
// small result queue taking up to two results a cycle and giving one
`default_nettype none

module p2p_res_queue
    import p2p_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [1:0] push_count,
    input  wire result_t    push0,
    input  wire result_t    push1,
    input  wire logic       pop,
    output result_t         head,
    output logic            not_empty,
    output logic            room2
);

    result_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = QPTR_W'(wr_ptr_reg + 1'b1);
    assign head         = mem[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    assign room2        = (count_reg <= QCNT_W'(QDEPTH - 2));

    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + QPTR_W'(push_count));
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push_count) - QCNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* src/pronunciation_to_phoneme_parser_unit.sv */
// top level of the phonetic-notation word parser
// usage:
//   characters of a word enter on the s_axis channel, one per request, and
//   a zero byte ends the word. each character registers into an input stage
//   and is parsed from there once the result queue has room for two results,
//   producing zero, one or two results that go into a four-entry result queue
//   feeding the m_axis channel. results carry a phoneme with its stress, a
//   word-done total or an error; tlast marks the last result caused by one
//   character. results are written into the result queue and offered on
//   m_axis from the queue head.
//   throughput: one character per cycle while the result queue has room for
//   two results; the output gives one result per cycle while the receiver is
//   ready, set by the single read port of the result queue.
//   when the receiver stalls, the queue fills and the input stage holds its
//   character until there is room for two results; s_axis_tready is low meanwhile.
//   max_phones is written through the apb port at addresses 0 to 3 (paddr[2] low).
//   reset empties the queue and the input stage, clears the word state and
//   sets max_phones to 31.
`default_nettype none

module pronunciation_to_phoneme_parser_unit
    import p2p_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_code
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // phone_id[5:0], stress[7:6], phone_count[13:8], syllable_count[19:14], zero
    output logic [23:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // is_phone, word_done, parse_error
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  char_reg;
    word_state_t ws_reg;
    word_state_t ws_next;
    logic [5:0]  max_phones_reg;
    logic        cfg_write;

    word_state_t core_ws_next;
    logic [1:0]  core_count;
    result_t     core_res0;
    result_t     core_res1;
    logic        process;
    logic        in_fire;
    logic        room2;
    result_t     head;
    logic [1:0]  push_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {26'd0, max_phones_reg} : 32'd0;

    assign process       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || process;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push_count    = process ? core_count : 2'd0;

    p2p_core u_core (
        .ws         (ws_reg),
        .char_code  (char_reg),
        .max_phones (max_phones_reg),
        .ws_next    (core_ws_next),
        .res_count  (core_count),
        .res0       (core_res0),
        .res1       (core_res1)
    );

    p2p_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (core_res0),
        .push1      (core_res1),
        .pop        (m_axis_tvalid && m_axis_tready),
        .head       (head),
        .not_empty  (m_axis_tvalid),
        .room2      (room2)
    );

    assign m_axis_tdata = {4'd0, head.syllable_count, head.phone_count,
                           head.stress, head.phone_id};
    assign m_axis_tuser = {head.parse_error, head.word_done, head.is_phone};
    assign m_axis_tlast = head.last_of_run;

    always_comb
    begin
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        ws_next = process ? core_ws_next : ws_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            char_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            ws_reg.parse_state        <= ST_START;
            ws_reg.pending_stress     <= STRESS_DEFAULT;
            ws_reg.phones             <= 6'd0;
            ws_reg.syllables          <= 6'd0;
            ws_reg.discarding         <= 1'b0;
            max_phones_reg            <= MAX_PHONES_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            ws_reg       <= ws_next;
            if (cfg_write)
            begin
                max_phones_reg <= pwdata[5:0];
            end
        end
    end

endmodule

`default_nettype wire
